### hw/rtl/pru_pkg.sv
// shared types, constants and register codes for the pixel replicate upscaler
package pru_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_SCALE_DEF = 16;

  localparam int SCALE_W = 5;
  localparam int LINE_WIDTH_W = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CNT_W = 6;
  localparam int PIX_W = 24;

  typedef enum logic [0:0] {
    REG_SCALE      = 1'b0,
    REG_LINE_WIDTH = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    OP_PIXEL  = 1'b0,
    OP_REPLAY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_PAD    = 2'd1,
    KIND_REJECT = 2'd2,
    KIND_EMPTY  = 2'd3
  } kind_t;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       end_of_row;
    logic       last;
  } out_item_t;

  // one accepted item waiting to be expanded into results
  typedef struct packed {
    kind_t              kind;
    logic               from_mem;
    pixel_t             pix;
    logic [SCALE_W-1:0] copies;
    logic [CNT_W-1:0]   total;
    logic               row_end;
    logic [1:0]         pad;
  } job_t;

endpackage

### hw/rtl/pru_line_mem.sv
// line store: single-port write, registered read with hold
module pru_line_mem #(
  parameter int DEPTH = pru_pkg::MAX_WIDTH_DEF,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  pru_pkg::pixel_t       wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output pru_pkg::pixel_t       rdata
);

  pru_pkg::pixel_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/pixel_replicate_upscaler.sv
// pixel replicate upscaler: nearest-neighbor integer upscale of a 24-bit pixel stream
// an item's first result passes the job register, then the output register
// throughput: one result per cycle while the output is not stalled; an item gives scale results,
//   plus the row padding (0 to 3) at a row end, one result for a rejected pixel or an empty replay
// the single output register and the job register set that pace; the next item is
//   taken in the cycle its last result moves out
// reset (sync, rst high) clears columns, pending rows, scale=1, line_width=1, keeps store
module pixel_replicate_upscaler #(
  parameter int MAX_WIDTH = pru_pkg::MAX_WIDTH_DEF,
  parameter int MAX_SCALE = pru_pkg::MAX_SCALE_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  pru_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output pru_pkg::out_item_t                 out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  pru_pkg::cfg_reg_t                  cfg_index,
  input  logic [pru_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int CMPW = (CW > pru_pkg::LINE_WIDTH_W) ? CW : pru_pkg::LINE_WIDTH_W;

  logic [pru_pkg::SCALE_W-1:0]      scale;
  logic [pru_pkg::LINE_WIDTH_W-1:0] line_width;
  logic [CW-1:0]                    write_column;
  logic [CW-1:0]                    replay_column;
  logic [RW-1:0]                    rows_to_replay;

  pru_pkg::job_t                    job;
  pru_pkg::job_t                    job_next;
  logic                             job_valid;
  logic [pru_pkg::CNT_W-1:0]        idx;

  logic [pru_pkg::SCALE_W-1:0]      eff_scale;
  logic [CMPW-1:0]                  last_col;
  logic [1:0]                       pad;
  logic [3:0]                       pad_prod;

  logic                             in_xfer;
  logic                             emit;
  logic                             job_done;

  logic                             mem_we;
  logic                             mem_re;
  pru_pkg::pixel_t                  mem_rdata;
  pru_pkg::pixel_t                  in_pix;
  pru_pkg::pixel_t                  cur_pix;
  pru_pkg::out_item_t               res;
  logic                             write_end;
  logic                             replay_end;

  // ---------------------------------------------------------------- config
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale      <= pru_pkg::SCALE_W'(1);
      line_width <= pru_pkg::LINE_WIDTH_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pru_pkg::REG_SCALE:      scale <= cfg_data[pru_pkg::SCALE_W-1:0];
        pru_pkg::REG_LINE_WIDTH: line_width <= cfg_data[pru_pkg::LINE_WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (scale == '0) begin
      eff_scale = pru_pkg::SCALE_W'(1);
    end else if (32'(scale) > 32'(MAX_SCALE)) begin
      eff_scale = pru_pkg::SCALE_W'(MAX_SCALE);
    end else begin
      eff_scale = scale;
    end
  end

  always_comb begin
    if (line_width == '0) begin
      last_col = '0;
    end else if (32'(line_width) > 32'(MAX_WIDTH)) begin
      last_col = CMPW'(MAX_WIDTH - 1);
    end else begin
      last_col = CMPW'(line_width - pru_pkg::LINE_WIDTH_W'(1));
    end
  end

  // row padding only depends on width and scale mod 4
  assign pad_prod = 4'(2'(last_col + CMPW'(1))) * 4'(eff_scale[1:0]) * 4'd3;
  assign pad      = 2'(3'd4 - 3'(pad_prod[1:0]));

  // ---------------------------------------------------------------- intake
  assign emit     = job_valid && (!out_valid || out_ready);
  assign job_done = emit && (idx == job.total - pru_pkg::CNT_W'(1));
  assign in_ready = !rst && (!job_valid || job_done);
  assign in_xfer  = in_valid && in_ready;

  assign in_pix     = {in_data.red, in_data.green, in_data.blue};
  assign write_end  = CMPW'(write_column) >= last_col;
  assign replay_end = CMPW'(replay_column) >= last_col;

  always_comb begin
    job_next        = '0;
    job_next.kind   = pru_pkg::KIND_PIXEL;
    job_next.copies = eff_scale;
    job_next.pad    = pad;
    job_next.total  = pru_pkg::CNT_W'(1);
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    if (in_data.op == pru_pkg::OP_PIXEL) begin
      if (rows_to_replay != '0) begin
        job_next.kind = pru_pkg::KIND_REJECT;
      end else begin
        mem_we           = in_xfer;
        job_next.pix     = in_pix;
        job_next.row_end = write_end;
        job_next.total   = pru_pkg::CNT_W'(eff_scale) +
                           (write_end ? pru_pkg::CNT_W'(pad) : '0);
      end
    end else begin
      if (rows_to_replay == '0) begin
        job_next.kind = pru_pkg::KIND_EMPTY;
      end else begin
        mem_re            = in_xfer;
        job_next.from_mem = 1'b1;
        job_next.row_end  = replay_end;
        job_next.total    = pru_pkg::CNT_W'(eff_scale) +
                            (replay_end ? pru_pkg::CNT_W'(pad) : '0);
      end
    end
  end

  // writes and replay reads come from distinct transfers, so a read never
  // meets a write of the same edge
  pru_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (write_column),
    .wdata (in_pix),
    .re    (mem_re),
    .raddr (replay_column),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      write_column   <= '0;
      replay_column  <= '0;
      rows_to_replay <= '0;
    end else if (in_xfer) begin
      if (mem_we) begin
        if (write_end) begin
          write_column   <= '0;
          replay_column  <= '0;
          rows_to_replay <= RW'(eff_scale - pru_pkg::SCALE_W'(1));
        end else begin
          write_column <= write_column + CW'(1);
        end
      end else if (mem_re) begin
        if (replay_end) begin
          replay_column  <= '0;
          rows_to_replay <= rows_to_replay - RW'(1);
        end else begin
          replay_column <= replay_column + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      idx       <= '0;
    end else if (in_xfer) begin
      job_valid <= 1'b1;
      idx       <= '0;
    end else if (job_done) begin
      job_valid <= 1'b0;
      idx       <= '0;
    end else if (emit) begin
      idx <= idx + pru_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      job <= job_next;
    end
  end

  // ---------------------------------------------------------------- results
  assign cur_pix = job.from_mem ? mem_rdata : job.pix;

  always_comb begin
    res      = '0;
    res.last = (idx == job.total - pru_pkg::CNT_W'(1));
    if (job.kind != pru_pkg::KIND_PIXEL) begin
      res.kind = job.kind;
    end else if (idx < pru_pkg::CNT_W'(job.copies)) begin
      res.kind       = pru_pkg::KIND_PIXEL;
      res.out_blue   = cur_pix[7:0];
      res.out_green  = cur_pix[15:8];
      res.out_red    = cur_pix[23:16];
      res.end_of_row = job.row_end && (job.pad == 2'd0) &&
                       (idx == pru_pkg::CNT_W'(job.copies) - pru_pkg::CNT_W'(1));
    end else begin
      res.kind       = pru_pkg::KIND_PAD;
      res.end_of_row = res.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= res;
    end
  end

`ifndef SYNTHESIS
  // rejects and empty replays are single closing results
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.kind == pru_pkg::KIND_REJECT ||
                  out_data.kind == pru_pkg::KIND_EMPTY)
    |-> out_data.last && !out_data.end_of_row)
    else $error("reject or empty result not a lone last transfer");

  // no new pixel is stored while repeats are pending
  a_replay_holds_write: assert property (@(posedge clk) disable iff (rst)
    rows_to_replay != '0 |-> write_column == '0)
    else $error("write column moved during replay");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> idx < job.total)
    else $error("result index past job length");

  // a finished job frees the intake in the same cycle
  a_done_frees_intake: assert property (@(posedge clk) disable iff (rst)
    job_done |-> in_ready)
    else $error("intake stalled on a finished job");
`endif

endmodule

### test/tb.sv
// testbench for the pixel replicate upscaler: directed and random streams vs a predictor
module tb;
  import pru_pkg::*;

  localparam int PERIOD = 12;
  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 40;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pixel_replicate_upscaler dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor copy of the block state
  logic [SCALE_W-1:0]      scale_reg = SCALE_W'(1);
  logic [LINE_WIDTH_W-1:0] width_reg = LINE_WIDTH_W'(1);
  pixel_t                  line_mem [MAX_WIDTH_DEF];
  int                      wr_col = 0;
  int                      rp_col = 0;
  int                      rows_pend = 0;
  out_item_t               upscaled_q [$];

  int errors = 0;
  int n_pixels = 0;
  int n_replays = 0;
  int n_results = 0;
  int n_rejects = 0;
  int n_empty = 0;
  int n_row_ends = 0;

  rx_mode_t rx_mode = RX_ALWAYS;
  int       hold_req = 0;
  int       burst_left = 0;
  bit       tx_gaps = 0;

  initial begin
    clk = 1'b0;
    forever #(PERIOD / 2) clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("timeout with %0d results outstanding", upscaled_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int eff_scale(logic [SCALE_W-1:0] v);
    if (v == 0) return 1;
    if (int'(v) > MAX_SCALE_DEF) return MAX_SCALE_DEF;
    return int'(v);
  endfunction

  function automatic int eff_width(logic [LINE_WIDTH_W-1:0] v);
    if (v == 0) return 1;
    if (int'(v) > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return int'(v);
  endfunction

  function automatic void push_result(kind_t k, pixel_t p, bit eor, bit lst);
    out_item_t r;
    r.kind = k;
    r.out_blue = p[7:0];
    r.out_green = p[15:8];
    r.out_red = p[23:16];
    r.end_of_row = eor;
    r.last = lst;
    upscaled_q.push_back(r);
    n_results++;
  endfunction

  // scale copies of one pixel, closed by the row padding at a row end
  function automatic void emit_copies(pixel_t p, bit row_end);
    int s;
    int w;
    int pad;
    int n;
    s = eff_scale(scale_reg);
    w = eff_width(width_reg);
    pad = (4 - (w * s * 3) % 4) % 4;
    n = s + (row_end ? pad : 0);
    for (int i = 0; i < s; i++)
      push_result(KIND_PIXEL, p, row_end && pad == 0 && i == s - 1, i == n - 1);
    if (row_end) begin
      for (int i = 0; i < pad; i++)
        push_result(KIND_PAD, '0, i == pad - 1, s + i == n - 1);
      n_row_ends++;
    end
  endfunction

  function automatic void upscale_item(in_item_t it);
    int     w;
    pixel_t p;
    bit     row_end;
    w = eff_width(width_reg);
    if (it.op == OP_PIXEL) begin
      if (rows_pend != 0) begin
        push_result(KIND_REJECT, '0, 1'b0, 1'b1);
        n_rejects++;
        return;
      end
      p = {it.red, it.green, it.blue};
      line_mem[wr_col % MAX_WIDTH_DEF] = p;
      row_end = wr_col >= w - 1;
      emit_copies(p, row_end);
      n_pixels++;
      if (row_end) begin
        wr_col = 0;
        rp_col = 0;
        rows_pend = eff_scale(scale_reg) - 1;
      end else begin
        wr_col++;
      end
    end else begin
      if (rows_pend == 0) begin
        push_result(KIND_EMPTY, '0, 1'b0, 1'b1);
        n_empty++;
        return;
      end
      p = line_mem[rp_col % MAX_WIDTH_DEF];
      row_end = rp_col >= w - 1;
      emit_copies(p, row_end);
      n_replays++;
      if (row_end) begin
        rp_col = 0;
        rows_pend--;
      end else begin
        rp_col++;
      end
    end
  endfunction

  function automatic in_item_t make_item(op_t op, pixel_t p);
    in_item_t it;
    it.op = op;
    it.red = p[23:16];
    it.green = p[15:8];
    it.blue = p[7:0];
    return it;
  endfunction

  // sender works in bursts when gaps are on; valid stays up across back-to-back items
  task automatic send_item(in_item_t it);
    int gap;
    @(negedge clk);
    if (tx_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    upscale_item(it);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == REG_SCALE) scale_reg = v[SCALE_W-1:0];
    else width_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (upscaled_q.size() != 0) @(posedge clk);
  endtask

  // receiver: long hold-off on request, otherwise the current stall pattern
  initial begin
    int cyc;
    int hold_left;
    cyc = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        case (rx_mode)
          RX_ALWAYS:   out_ready <= 1'b1;
          RX_RANDOM:   out_ready <= ($urandom_range(0, 99) < 65);
          RX_PERIODIC: out_ready <= ((cyc % 11) < 6);
          default:     out_ready <= ((cyc % 29) > 1);
        endcase
      end
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (upscaled_q.size() == 0) begin
        $display("%0t unexpected transfer: expected none, got kind %0d pixel %h", $time,
                 out_data.kind, {out_data.out_red, out_data.out_green, out_data.out_blue});
        errors++;
      end else begin
        want = upscaled_q.pop_front();
        check_field("kind", 8'(want.kind), 8'(out_data.kind));
        check_field("out_blue", want.out_blue, out_data.out_blue);
        check_field("out_green", want.out_green, out_data.out_green);
        check_field("out_red", want.out_red, out_data.out_red);
        check_field("end_of_row", 8'(want.end_of_row), 8'(out_data.end_of_row));
        check_field("last", 8'(want.last), 8'(out_data.last));
      end
    end
  end

  // defaults after reset: scale 1, width 1, so every pixel closes a row with one pad byte
  task automatic test_reset_defaults();
    rx_mode = RX_ALWAYS;
    tx_gaps = 0;
    send_item(make_item(OP_PIXEL, 24'hFFFFFF));
    send_item(make_item(OP_REPLAY, 24'hFFFFFF));
    send_item(make_item(OP_PIXEL, 24'h000000));
    drain();
  endtask

  // scale 0 acts as 1, scale 31 as the maximum; pixel during repeats and an empty replay
  task automatic test_scale_limits();
    rx_mode = RX_RANDOM;
    tx_gaps = 1;
    write_reg(REG_SCALE, 11'd0);
    write_reg(REG_LINE_WIDTH, 11'd1);
    send_item(make_item(OP_PIXEL, 24'hA5C35A));
    drain();
    write_reg(REG_SCALE, 11'd31);
    send_item(make_item(OP_PIXEL, 24'h123456));
    send_item(make_item(OP_PIXEL, 24'hEDCBA9));
    repeat (15) send_item(make_item(OP_REPLAY, 24'h000000));
    send_item(make_item(OP_REPLAY, 24'hFFFFFF));
    drain();
  endtask

  // width cut below the write column closes the row; scale changed while repeats pend
  task automatic test_width_shrink();
    rx_mode = RX_PERIODIC;
    tx_gaps = 1;
    write_reg(REG_SCALE, 11'd3);
    write_reg(REG_LINE_WIDTH, 11'd2047);
    send_item(make_item(OP_PIXEL, 24'h010203));
    send_item(make_item(OP_PIXEL, 24'h808080));
    send_item(make_item(OP_PIXEL, 24'h7F7F7F));
    drain();
    write_reg(REG_LINE_WIDTH, 11'd2);
    send_item(make_item(OP_PIXEL, 24'hFEDCBA));
    repeat (2) send_item(make_item(OP_REPLAY, 24'h555555));
    drain();
    write_reg(REG_SCALE, 11'd2);
    repeat (2) send_item(make_item(OP_REPLAY, 24'hAAAAAA));
    drain();
    write_reg(REG_LINE_WIDTH, 11'd0);
    send_item(make_item(OP_PIXEL, 24'h3C3C3C));
    send_item(make_item(OP_REPLAY, 24'hC3C3C3));
    drain();
  endtask

  // receiver holds off while the sender keeps offering, so the input side backs up
  task automatic test_output_stall();
    rx_mode = RX_ALWAYS;
    tx_gaps = 0;
    write_reg(REG_SCALE, 11'd4);
    write_reg(REG_LINE_WIDTH, 11'd3);
    @(posedge clk);
    hold_req = 300;
    repeat (3) send_item(make_item(OP_PIXEL, pixel_t'($urandom_range(0, 24'hFFFFFF))));
    repeat (9) send_item(make_item(OP_REPLAY, pixel_t'($urandom_range(0, 24'hFFFFFF))));
    drain();
  endtask

  // mostly well-formed rows and their repeats, with some out-of-order items mixed in
  task automatic test_random_stream(int target);
    int                      counted;
    int                      phase_len;
    int                      r;
    op_t                     op;
    logic [5:0]              hi;
    logic [SCALE_W-1:0]      s_new;
    logic [LINE_WIDTH_W-1:0] w_new;
    counted = 0;
    while (counted < target) begin
      drain();
      if ($urandom_range(0, 2) != 0) begin
        r = $urandom_range(0, 9);
        case (r)
          0:       s_new = 5'd0;
          1:       s_new = 5'd16;
          2:       s_new = 5'd31;
          3:       s_new = 5'd1;
          default: s_new = 5'($urandom_range(2, 6));
        endcase
        hi = 6'($urandom_range(0, 63));
        write_reg(REG_SCALE, {hi, s_new});
      end
      if ($urandom_range(0, 2) != 0) begin
        if ($urandom_range(0, 5) == 0) w_new = 11'($urandom_range(7, 12));
        else w_new = 11'($urandom_range(0, 6));
        // growing the width while repeats pend would replay columns never written
        if (rows_pend == 0 || eff_width(w_new) <= eff_width(width_reg))
          write_reg(REG_LINE_WIDTH, w_new);
      end
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      tx_gaps = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(15, 45);
      repeat (phase_len) begin
        r = $urandom_range(0, 99);
        if (rows_pend != 0) op = (r < 90) ? OP_REPLAY : OP_PIXEL;
        else op = (r < 90) ? OP_PIXEL : OP_REPLAY;
        counted++;
        send_item(make_item(op, pixel_t'($urandom_range(0, 24'hFFFFFF))));
      end
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_SCALE;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_scale_limits();
    test_width_shrink();
    test_output_stall();
    test_random_stream(225);

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d pixels and %0d repeat steps, %0d rows closed, %0d results checked",
             n_pixels, n_replays, n_row_ends, n_results);
    $display("plus %0d pixels rejected during repeats and %0d empty repeat steps",
             n_rejects, n_empty);
    if (errors == 0 && upscaled_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results never seen", errors, upscaled_q.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/pru_pkg.sv
hw/rtl/pru_line_mem.sv
hw/rtl/pixel_replicate_upscaler.sv
test/tb.sv
